/* hdl/assert_macros.svh */
// Assertion macros for the checker file of the text console engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text console check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text console check failed");

`endif

/* hdl/tcce_pkg.sv */
// Package of the text console engine: geometry constants, codes and helpers.
// No dependencies; imported by the engine and its checker.
package tcce_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_STOP  = 4;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;

    localparam logic [7:0]  BLANK_COLOR = 8'h07;
    localparam logic [15:0] BLANK_GLYPH = {BLANK_COLOR, 8'h00};

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_SETPOS = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Store address of a screen cell. The screen is a ring of rows whose
    // first row sits at physical row top.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        int phys;
        phys = int'(row) + int'(top);
        if (phys >= ROWS) begin
            phys = phys - ROWS;
        end
        return ADDR_W'(phys * COLUMNS + int'(col));
    endfunction

    // True when the column is a tab stop.
    function automatic logic tab_hit(input logic [COL_W-1:0] col);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= COLUMNS / TAB_STOP; k++) begin
            hit = hit | (int'(col) == k * TAB_STOP);
        end
        return hit;
    endfunction

endpackage

/* hdl/text_console_char_engine.sv */
// Top level of the text console engine: glyph store, cursor and sequencer.
// Depends on tcce_pkg.
//
// The engine keeps a screen of ROWS x COLUMNS glyphs (character byte in the
// low half, attribute byte in the high half) in one synchronous memory with
// one write and one registered read port, plus a cursor. Each request on the
// slave stream carries an operation in tuser and a character, column and row
// in tdata, and produces exactly one response on the master stream with the
// cursor after the request and, for a cell read, the cell contents. Requests
// are handled one at a time. A printable byte is written in the put step; a
// pending line wrap first takes its newline in that step, and a tab writes
// one space at a time up to the next tab stop. A cell read goes through the
// read data step unless it lies off the screen. Scrolling does not move the
// screen contents: the row ring is rotated by one and the new bottom row is
// blanked at one cell per cycle. Clearing the screen writes every cell once.
// After reset the same clearing pass runs before the first request is taken;
// configuration writes of the text color are taken in every cycle, including
// during that pass, and apply to characters printed afterwards. A response
// that waits on a stalled master side holds the engine in its finishing step
// until it is taken.
module text_console_char_engine
    import tcce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: tuser = operation[1:0]
    //             tdata = char_code[7:0], column[14:8], row[19:15], zero[23:20]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,
    input  logic [23:0] i_s_tdata,
    // Master side: tdata = cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
    //                      cell_color[27:20], zero[31:28]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    // Text color register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_EXEC,
        S_RDATA,
        S_SWEEP,
        S_DONE
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [ADDR_W-1:0]  r_swp_addr, n_swp_addr;
    logic [ADDR_W-1:0]  r_swp_last, n_swp_last;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [7:0]         r_color, n_color;
    logic               r_out_valid, n_out_valid;
    logic               r_tab, n_tab;

    // Request and response payload.
    t_op                r_op, n_op;
    logic [7:0]         r_char, n_char;
    logic [COL_W-1:0]   r_col_in, n_col_in;
    logic [ROW_W-1:0]   r_row_in, n_row_in;
    logic [7:0]         r_res_char, n_res_char;
    logic [7:0]         r_res_color, n_res_color;
    logic [COL_W-1:0]   r_out_col, n_out_col;
    logic [ROW_W-1:0]   r_out_row, n_out_row;
    logic [7:0]         r_out_char, n_out_char;
    logic [7:0]         r_out_color, n_out_color;

    // Glyph store.
    logic [15:0]        r_glyph_mem [CELLS];
    logic [15:0]        r_rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [15:0]        wr_data;

    logic               s_acc;
    logic               out_free;
    logic               in_range;
    logic               line_dn;
    t_state             ln_ret;
    logic               do_finish;

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {4'b0000, r_out_color, r_out_char, r_out_row, r_out_col};

    assign in_range = (int'(r_col_in) < COLUMNS) && (int'(r_row_in) < ROWS);
    assign rd_addr  = cell_addr(r_top, r_row_in, r_col_in);

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_swp_addr  = r_swp_addr;
        n_swp_last  = r_swp_last;
        n_top       = r_top;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_color     = r_color;
        n_out_valid = r_out_valid;
        n_tab       = r_tab;
        n_op        = r_op;
        n_char      = r_char;
        n_col_in    = r_col_in;
        n_row_in    = r_row_in;
        n_res_char  = r_res_char;
        n_res_color = r_res_color;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_char  = r_out_char;
        n_out_color = r_out_color;
        wr_en       = 1'b0;
        wr_addr     = r_swp_addr;
        wr_data     = BLANK_GLYPH;
        line_dn     = 1'b0;
        ln_ret      = S_DONE;
        do_finish   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op        = t_op'(i_s_tuser);
                    n_char      = i_s_tdata[7:0];
                    n_col_in    = i_s_tdata[14:8];
                    n_row_in    = i_s_tdata[19:15];
                    n_res_char  = 8'h00;
                    n_res_color = 8'h00;
                    n_tab       = 1'b0;
                    n_state     = (t_op'(i_s_tuser) == OP_PUT) ? S_PUT : S_EXEC;
                end
            end
            S_PUT: begin
                if (int'(r_cur_col) >= COLUMNS) begin
                    // Pending wrap: newline first, with any scroll, then the byte.
                    n_cur_col = '0;
                    line_dn   = 1'b1;
                    ln_ret    = S_PUT;
                end else if (r_char inside {[CH_SPACE:CH_DEL]}) begin
                    wr_en     = 1'b1;
                    wr_addr   = cell_addr(r_top, r_cur_row, r_cur_col);
                    wr_data   = {r_color, r_char};
                    n_cur_col = r_cur_col + 1'b1;
                    if (!(r_tab && !tab_hit(n_cur_col) && (int'(n_cur_col) < COLUMNS))) begin
                        do_finish = 1'b1;
                    end
                end else begin
                    case (r_char)
                        CH_BS: begin
                            if (r_cur_col != '0 || r_cur_row != '0) begin
                                if (r_cur_col == '0) begin
                                    n_cur_col = COL_W'(COLUMNS - 1);
                                    n_cur_row = r_cur_row - 1'b1;
                                end else begin
                                    n_cur_col = r_cur_col - 1'b1;
                                end
                                wr_en   = 1'b1;
                                wr_addr = cell_addr(r_top, n_cur_row, n_cur_col);
                                wr_data = BLANK_GLYPH;
                            end
                            do_finish = 1'b1;
                        end
                        CH_HT: begin
                            // Continue as a run of spaces up to the next stop.
                            n_char = CH_SPACE;
                            n_tab  = 1'b1;
                        end
                        CH_LF: begin
                            n_cur_col = '0;
                            line_dn   = 1'b1;
                        end
                        CH_VT, CH_FF: begin
                            line_dn = 1'b1;
                        end
                        CH_CR: begin
                            n_cur_col = '0;
                            do_finish = 1'b1;
                        end
                        default: begin
                            do_finish = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_SETPOS: begin
                        if (in_range) begin
                            n_cur_col = r_col_in;
                            n_cur_row = r_row_in;
                        end
                        do_finish = 1'b1;
                    end
                    OP_CLEAR: begin
                        n_swp_addr = '0;
                        n_swp_last = ADDR_W'(CELLS - 1);
                        n_ret      = S_DONE;
                        n_state    = S_SWEEP;
                    end
                    OP_READ: begin
                        // The read port is addressed from the latched request.
                        if (in_range) begin
                            n_state = S_RDATA;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                    default: begin
                        do_finish = 1'b1;
                    end
                endcase
            end
            S_RDATA: begin
                n_res_char  = r_rd_data[7:0];
                n_res_color = r_rd_data[15:8];
                do_finish   = 1'b1;
            end
            S_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = r_swp_addr;
                wr_data = BLANK_GLYPH;
                if (r_swp_addr == r_swp_last) begin
                    if (r_ret == S_DONE) begin
                        do_finish = 1'b1;
                    end else begin
                        n_state = r_ret;
                    end
                end else begin
                    n_swp_addr = r_swp_addr + 1'b1;
                end
            end
            S_DONE: begin
                do_finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Line down: next row, or rotate the row ring and blank the row that
        // becomes the bottom one.
        if (line_dn) begin
            if (int'(r_cur_row) < ROWS - 1) begin
                n_cur_row = r_cur_row + 1'b1;
                if (ln_ret == S_DONE) begin
                    do_finish = 1'b1;
                end
            end else begin
                n_swp_addr = cell_addr(r_top, '0, '0);
                n_swp_last = n_swp_addr + ADDR_W'(COLUMNS - 1);
                n_top      = (int'(r_top) == ROWS - 1) ? '0 : r_top + 1'b1;
                n_ret      = ln_ret;
                n_state    = S_SWEEP;
            end
        end

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (do_finish) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_col   = n_cur_col;
                n_out_row   = n_cur_row;
                n_out_char  = n_res_char;
                n_out_color = n_res_color;
                n_state     = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end

        if (i_cfg_valid) begin
            n_color = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_char      <= n_char;
        r_col_in    <= n_col_in;
        r_row_in    <= n_row_in;
        r_res_char  <= n_res_char;
        r_res_color <= n_res_color;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_char  <= n_out_char;
        r_out_color <= n_out_color;
        if (!i_rst_n) begin
            // Reset starts the clearing pass over the whole store.
            r_state     <= S_SWEEP;
            r_ret       <= S_IDLE;
            r_swp_addr  <= '0;
            r_swp_last  <= ADDR_W'(CELLS - 1);
            r_top       <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_color     <= BLANK_COLOR;
            r_out_valid <= 1'b0;
            r_tab       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_swp_addr  <= n_swp_addr;
            r_swp_last  <= n_swp_last;
            r_top       <= n_top;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_color     <= n_color;
            r_out_valid <= n_out_valid;
            r_tab       <= n_tab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_glyph_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_glyph_mem[rd_addr];
    end

endmodule

/* hdl/tcce_checker.sv */
// Port-level checker of the text console engine, bound to its top level.
// Depends on tcce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcce_checker
    import tcce_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic [23:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_data
);

    // A stalled response stays and keeps its contents.
    `TCCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // The cursor column never passes the wrap-pending position.
    `TCCE_ASSERT_NOW(a_col_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[6:0] <= 7'(COLUMNS))

    // The cursor row stays on the screen.
    `TCCE_ASSERT_NOW(a_row_range, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[11:7] < 5'(ROWS))

    // Requests are worked one at a time: a taken request closes the input.
    `TCCE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind text_console_char_engine tcce_checker u_tcce_checker (.*);

/* bench/console_response_checker.sv */
// Response checker for the text console engine: predicts every response from the
// accepted requests and text color writes, and compares it with the master stream.
// Depends on tcce_pkg for the screen geometry, control codes and operation codes.
module console_response_checker
    import tcce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    input  logic [23:0] i_s_tdata,   // char_code[7:0], column[14:8], row[19:15], zero[23:20]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
                                     // cell_color[27:20], zero[31:28]
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_responses_checked,
    output int          o_scrolls,
    output int          o_wraps
);
    timeunit 1ns;
    timeprecision 1ps;

    // Same layout as the low 28 bits of the master tdata.
    typedef struct packed {
        logic [7:0] cell_color;
        logic [7:0] cell_char;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } t_console_resp;

    logic [15:0]   screen [CELLS];
    logic [6:0]    cur_col;
    logic [4:0]    cur_row;
    logic [7:0]    text_color;
    t_console_resp expected_responses [$];
    int            fails;
    int            checked;
    int            scrolls;
    int            wraps;

    task automatic blank_row(input int r);
        for (int c = 0; c < COLUMNS; c++) begin
            screen[r * COLUMNS + c] = BLANK_GLYPH;
        end
    endtask

    task automatic clear_screen();
        for (int r = 0; r < ROWS; r++) begin
            blank_row(r);
        end
    endtask

    task automatic scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        blank_row(ROWS - 1);
        scrolls++;
    endtask

    task automatic next_line();
        if (int'(cur_row) < ROWS - 1) begin
            cur_row = cur_row + 1'b1;
        end else begin
            scroll_screen();
        end
    endtask

    task automatic store_glyph(input logic [7:0] code);
        screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {text_color, code};
        cur_col = cur_col + 1'b1;
    endtask

    task automatic print_code(input logic [7:0] code);
        // A cursor parked past the last column moves to the next line first.
        if (int'(cur_col) >= COLUMNS) begin
            cur_col = '0;
            next_line();
            wraps++;
        end
        if (code >= CH_SPACE && code <= CH_DEL) begin
            store_glyph(code);
        end else begin
            case (code)
                CH_BS: begin
                    if (cur_col != '0 || cur_row != '0) begin
                        if (cur_col == '0) begin
                            cur_col = 7'(COLUMNS - 1);
                            cur_row = cur_row - 1'b1;
                        end else begin
                            cur_col = cur_col - 1'b1;
                        end
                        screen[int'(cur_row) * COLUMNS + int'(cur_col)] = BLANK_GLYPH;
                    end
                end
                CH_HT: begin
                    // The wrap was taken above, so the spaces never wrap here.
                    store_glyph(CH_SPACE);
                    while (int'(cur_col) % TAB_STOP != 0 && int'(cur_col) < COLUMNS) begin
                        store_glyph(CH_SPACE);
                    end
                end
                CH_LF: begin
                    cur_col = '0;
                    next_line();
                end
                CH_VT, CH_FF: begin
                    next_line();
                end
                CH_CR: begin
                    cur_col = '0;
                end
                default: begin
                end
            endcase
        end
    endtask

    function automatic logic on_screen(input logic [6:0] col, input logic [4:0] row);
        return int'(col) < COLUMNS && int'(row) < ROWS;
    endfunction

    task automatic predict_request(input t_op op, input logic [7:0] code,
                                   input logic [6:0] col, input logic [4:0] row);
        t_console_resp resp;
        logic [15:0]   glyph;
        resp = '0;
        case (op)
            OP_PUT: begin
                print_code(code);
            end
            OP_SETPOS: begin
                if (on_screen(col, row)) begin
                    cur_col = col;
                    cur_row = row;
                end
            end
            OP_CLEAR: begin
                clear_screen();
            end
            OP_READ: begin
                if (on_screen(col, row)) begin
                    glyph           = screen[int'(row) * COLUMNS + int'(col)];
                    resp.cell_char  = glyph[7:0];
                    resp.cell_color = glyph[15:8];
                end
            end
            default: begin
            end
        endcase
        resp.cursor_col = cur_col;
        resp.cursor_row = cur_row;
        expected_responses.push_back(resp);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_console_resp seen;
        t_console_resp want;
        if (!i_rst_n) begin
            clear_screen();
            cur_col    = '0;
            cur_row    = '0;
            text_color = BLANK_COLOR;
            expected_responses.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                text_color = i_cfg_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                seen = t_console_resp'(i_m_tdata[27:0]);
                if (expected_responses.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, i_m_tdata);
                end else begin
                    want = expected_responses.pop_front();
                    checked++;
                    check_field("cursor_col", want.cursor_col, seen.cursor_col);
                    check_field("cursor_row", want.cursor_row, seen.cursor_row);
                    check_field("cell_char", want.cell_char, seen.cell_char);
                    check_field("cell_color", want.cell_color, seen.cell_color);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_request(t_op'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[14:8],
                                i_s_tdata[19:15]);
            end
        end
        o_fail_count        <= fails;
        o_responses_checked <= checked;
        o_scrolls           <= scrolls;
        o_wraps             <= wraps;
    end

endmodule

/* bench/text_console_char_engine_tb.sv */
// Testbench top of the text console engine: clock, reset, request stimulus,
// response back-pressure and the final verdict.
// Depends on tcce_pkg, console_response_checker and text_console_char_engine.
module text_console_char_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    // The slowest legal run stays far below this: about 1850 requests at
    // worst a scroll plus a tab each, long gaps and stalls on both sides,
    // a few dozen full screen clears and the clearing pass after reset.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 305;
    // The receiver goes quiet once, for this long, after this many responses.
    localparam int HOLD_AFTER  = 500;
    localparam int HOLD_CYCLES = 400;
    // A scroll blanks a whole row, the longest step short of a clear.
    localparam int TAIL_CYCLES = 120;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BELL = 8'h07;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [1:0]  i_s_tuser   = '0;
    logic [23:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data  = '0;

    // While set, neither side idles or stalls.
    logic        steady      = 1'b0;

    int fail_count;
    int responses_checked;
    int scroll_count;
    int wrap_count;
    int requests_sent = 0;
    int clears_sent   = 0;
    int color_writes  = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    text_console_char_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    console_response_checker response_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_s_tvalid          (i_s_tvalid),
        .i_s_tready          (o_s_tready),
        .i_s_tuser           (i_s_tuser),
        .i_s_tdata           (i_s_tdata),
        .i_m_tvalid          (o_m_tvalid),
        .i_m_tready          (i_m_tready),
        .i_m_tdata           (o_m_tdata),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_responses_checked (responses_checked),
        .o_scrolls           (scroll_count),
        .o_wraps             (wrap_count)
    );

    // Idle length for either side: mostly none or short, now and then
    // a long one, so that gaps land on every step of the engine's work.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // Rows near the bottom make line feeds scroll and wrapped lines run off.
    function automatic logic [4:0] pick_row();
        if ($urandom_range(0, 1) == 0) begin
            return 5'($urandom_range(ROWS - 5, ROWS - 1));
        end
        return 5'($urandom_range(0, ROWS - 1));
    endfunction

    // Columns near the right edge make printing run into a pending wrap.
    function automatic logic [6:0] pick_column();
        if ($urandom_range(0, 9) < 3) begin
            return 7'($urandom_range(COLUMNS - 8, COLUMNS - 1));
        end
        return 7'($urandom_range(0, COLUMNS - 1));
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) begin
            return 8'($urandom_range(CH_SPACE, CH_DEL));
        end
        if (r < 68) begin
            return CH_HT;
        end
        if (r < 76) begin
            return CH_LF;
        end
        if (r < 80) begin
            return ($urandom_range(0, 1) == 0) ? CH_VT : CH_FF;
        end
        if (r < 84) begin
            return CH_CR;
        end
        if (r < 91) begin
            return CH_BS;
        end
        return 8'($urandom);
    endfunction

    // Offers one request and returns at the edge where it is accepted. The
    // valid is only lowered when a gap follows, so back-to-back requests
    // keep it high with a single assignment per edge.
    task automatic send_request(input t_op op, input logic [7:0] code,
                                input logic [6:0] col, input logic [4:0] row);
        int gap;
        gap = steady ? 0 : pick_pause();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0000, row, col, code};
        do @(posedge i_clk); while (!o_s_tready);
        requests_sent++;
        if (op == OP_CLEAR) begin
            clears_sent++;
        end
    endtask

    // The fields a put does not use still carry random bits.
    task automatic put_code(input logic [7:0] code);
        send_request(OP_PUT, code, 7'($urandom), 5'($urandom));
    endtask

    task automatic set_cursor(input logic [6:0] col, input logic [4:0] row);
        send_request(OP_SETPOS, 8'($urandom), col, row);
    endtask

    task automatic read_cell(input logic [6:0] col, input logic [4:0] row);
        send_request(OP_READ, 8'($urandom), col, row);
    endtask

    task automatic clear_all_cells();
        send_request(OP_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
    endtask

    // Mostly puts, a fair share of cursor moves and reads aimed at the
    // busy part of the screen, some out-of-range coordinates, rare clears.
    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 999);
        if (r < 5) begin
            clear_all_cells();
        end else if (r < 100) begin
            if ($urandom_range(0, 4) == 0) begin
                set_cursor(7'($urandom), 5'($urandom));
            end else begin
                set_cursor(pick_column(), pick_row());
            end
        end else if (r < 230) begin
            if ($urandom_range(0, 9) < 3) begin
                read_cell(7'($urandom), 5'($urandom));
            end else begin
                read_cell(pick_column(), pick_row());
            end
        end else begin
            put_code(pick_code());
        end
    endtask

    task automatic write_text_color(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        color_writes++;
    endtask

    // Every request yields one response, so the engine is idle once the
    // checker has matched as many responses as requests went out. The count
    // lags the edge by one update, which only makes the wait longer.
    task automatic wait_drained(input int settle);
        while (responses_checked != requests_sent) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Response side: ready stretches alternate with stalls. Once, in the
    // middle of the random part, the receiver holds off for a long stretch
    // while the sender keeps offering, so the engine backs up to its input.
    initial begin : response_sink
        int n;
        bit held;
        held = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            i_m_tready <= 1'b1;
            n = steady ? 1 : $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
            if (!held && !steady && responses_checked >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = steady ? 0 : pick_pause();
                if (n > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: run stopped after %0d cycles without finishing", $time, CYCLE_LIMIT);
        $display("FAIL text_console_char_engine");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] phase_colors [PHASES];
        phase_colors = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), 8'h80, BLANK_COLOR};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The engine takes color writes even during its clearing pass after
        // reset, so the first write goes in right away.
        write_text_color(8'h1E);

        // Directed part. A blank cell reads back with the default color.
        read_cell(7'd0, 5'd0);
        // Printable range ends and a plain letter.
        put_code(8'h41);
        put_code(CH_SPACE);
        put_code(CH_DEL);
        // Bytes that must leave screen and cursor alone.
        put_code(CH_NUL);
        put_code(CH_BELL);
        put_code(8'h80);
        put_code(8'hFF);
        // Backspace inside a row blanks the cell it lands on.
        put_code(CH_BS);
        read_cell(7'd0, 5'd0);
        put_code(CH_CR);
        // Backspace at the top-left corner does nothing.
        put_code(CH_BS);
        put_code(CH_HT);
        // A letter in the last column leaves a wrap pending; a backspace then
        // wraps first and comes back to the end of the row above.
        set_cursor(7'(COLUMNS - 1), 5'd0);
        put_code(8'h42);
        put_code(CH_BS);
        // Out-of-range cursor sets and reads are ignored.
        set_cursor(7'h7F, 5'h1F);
        set_cursor(7'(COLUMNS), 5'd3);
        set_cursor(7'd5, 5'(ROWS));
        read_cell(7'h7F, 5'h1F);
        // A tab ending on the right edge, then a newline on the bottom row:
        // the pending wrap scrolls once and the newline scrolls again.
        set_cursor(7'(COLUMNS - 2), 5'(ROWS - 1));
        put_code(CH_HT);
        put_code(CH_LF);
        put_code(CH_VT);
        put_code(CH_FF);
        put_code(8'h5A);
        clear_all_cells();
        read_cell(7'd0, 5'(ROWS - 1));
        i_s_tvalid <= 1'b0;
        wait_drained(4);

        // Random part, in phases with a new text color each. The third phase
        // runs with both sides streaming without a break.
        for (int p = 0; p < PHASES; p++) begin
            steady <= (p == 2);
            write_text_color(phase_colors[p]);
            repeat (PHASE_ITEMS) send_random_request();
            i_s_tvalid <= 1'b0;
            wait_drained((p == PHASES - 1) ? TAIL_CYCLES : 4);
        end

        $display("Sent %0d requests, %0d of them screen clears, under %0d text colors; %0d responses matched.",
                 requests_sent, clears_sent, color_writes, responses_checked);
        $display("The screen scrolled %0d times and %0d pending line wraps were taken.",
                 scroll_count, wrap_count);
        if (fail_count == 0) begin
            $display("PASS text_console_char_engine");
        end else begin
            $display("FAIL text_console_char_engine");
        end
        $finish;
    end

endmodule
